/* rtl/page_buffer_pool_manager_assert.svh */
// Assertion macros for the page buffer pool manager
`ifndef PAGE_BUFFER_POOL_MANAGER_ASSERT_SVH
`define PAGE_BUFFER_POOL_MANAGER_ASSERT_SVH
// implication check on clk, idle in reset
`define PBPM_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication check
`define PBPM_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* rtl/pbpm_pkg.sv */
// ---------------------------------------------------------------------------
// pbpm_pkg: shared types and constants
// Opcodes, status codes, controller states and command/status structs.
// ---------------------------------------------------------------------------
package pbpm_pkg;
  localparam int POOL_FRAMES = 16;
  localparam int PIN_BITS    = 8;
  localparam int FW          = $clog2(POOL_FRAMES);
  localparam int CW          = $clog2(POOL_FRAMES + 1);
  localparam int PW          = 31;

  localparam logic [2:0] OP_FETCH  = 3'd0;
  localparam logic [2:0] OP_NEW    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_UNPIN  = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FRAME = 3'd1;
  localparam logic [2:0] ST_NOT_RES  = 3'd2;
  localparam logic [2:0] ST_PINNED   = 3'd3;
  localparam logic [2:0] ST_UNPINNED = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_LRU, S_OUT
  } state_t;

  typedef struct packed {
    logic load;     // capture request
    logic scan;     // step lookup scan
    logic exec;     // apply frame update
    logic lru_step; // step LRU compaction
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic lru_done;
  } stat_t;
endpackage

/* rtl/page_buffer_pool_manager.sv */
// ---------------------------------------------------------------------------
// page_buffer_pool_manager: buffer pool frame manager with LRU eviction
// Top level joining the request sequencer and the frame datapath.
// ---------------------------------------------------------------------------
// Usage: a request beat on in_* (opcode, page ids, mark_dirty) is taken
// when in_valid and in_ready are high; one result beat follows on out_*.
// One request is in flight at a time; in_ready is high only when idle.
// Sequence: the accepting edge captures the request, then a lookup scan
// of one frame per cycle (ending after the first hit or the last frame),
// one update step, then LRU compaction of one entry per cycle, then the
// result; in_ready rises in the cycle after the result beat.
// Reset empties every frame, fills the free queue with all frames in
// order and clears the LRU order; no clearing pass is needed.
// When the receiver stalls, the result holds on out_* and no new
// request is taken until out_ready accepts it.
// ---------------------------------------------------------------------------
`include "page_buffer_pool_manager_assert.svh"
module page_buffer_pool_manager import pbpm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_opcode,
  input  logic [PW-1:0] in_page_id,
  input  logic          in_mark_dirty,
  input  logic [PW-1:0] in_new_page_id,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [FW-1:0] out_frame_index,
  output logic [PW-1:0] out_result_page_id,
  output logic          out_writeback_valid,
  output logic [PW-1:0] out_writeback_page_id,
  output logic [FW-1:0] out_writeback_frame,
  output logic          out_read_valid,
  output logic          out_release_valid
);
  cmd_t  cmd;
  stat_t stat;

  pbpm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  pbpm_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_opcode, .in_page_id, .in_mark_dirty, .in_new_page_id,
    .out_status, .out_frame_index, .out_result_page_id,
    .out_writeback_valid, .out_writeback_page_id, .out_writeback_frame,
    .out_read_valid, .out_release_valid
  );

  `PBPM_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "ready while result pending")
  `PBPM_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready, "accept did not start work")
  `PBPM_ASSERT_IMP(a_wb_release, out_valid && out_release_valid, out_status == ST_OK, "release without ok")
endmodule

/* rtl/pbpm_ctrl.sv */
// ---------------------------------------------------------------------------
// pbpm_ctrl: request sequencer
// Steps each request through lookup, update, LRU compaction and output.
// ---------------------------------------------------------------------------
module pbpm_ctrl import pbpm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);
  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // sequence the request
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // take no beat while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_LRU;
      end
      S_LRU: begin
        cmd.lru_step = 1'b1;
        if (stat.lru_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* rtl/pbpm_datapath.sv */
// ---------------------------------------------------------------------------
// pbpm_datapath: frame table, free queue and LRU order
// Scans the frame table, applies one request, compacts the queues.
// ---------------------------------------------------------------------------
module pbpm_datapath import pbpm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  output stat_t           stat,
  input  logic [2:0]      in_opcode,
  input  logic [PW-1:0]   in_page_id,
  input  logic            in_mark_dirty,
  input  logic [PW-1:0]   in_new_page_id,
  output logic [2:0]      out_status,
  output logic [FW-1:0]   out_frame_index,
  output logic [PW-1:0]   out_result_page_id,
  output logic            out_writeback_valid,
  output logic [PW-1:0]   out_writeback_page_id,
  output logic [FW-1:0]   out_writeback_frame,
  output logic            out_read_valid,
  output logic            out_release_valid
);
  localparam logic [PIN_BITS-1:0] PinMax = '1;
  localparam logic [CW-1:0] Full = CW'(POOL_FRAMES);

  logic [POOL_FRAMES-1:0] valid_r, dirty_r;
  logic [PW-1:0]          page_r [POOL_FRAMES];
  logic [PIN_BITS-1:0]    pins_r [POOL_FRAMES];
  logic [FW-1:0]          freeq_r [POOL_FRAMES];
  logic [FW-1:0]          lru_r [POOL_FRAMES];
  logic [CW-1:0]          free_cnt_r, lru_cnt_r;

  logic [2:0]    op_r;
  logic [PW-1:0] pg_r, npg_r;
  logic          md_r;
  logic [CW-1:0] scan_r;
  logic          hit_r;
  logic [FW-1:0] hidx_r;

  // LRU removal: position being compacted, and target frame
  logic          rm_act_r;
  logic [FW-1:0] rm_f_r;
  logic [CW-1:0] rm_i_r;
  logic          rm_found_r;
  logic          app_r;

  logic [2:0]    st_r;
  logic [FW-1:0] fi_r, wbf_r;
  logic [PW-1:0] rp_r, wbp_r;
  logic          wb_r, rd_r, rel_r;

  logic [FW-1:0] si;
  assign si = scan_r[FW-1:0];

  assign stat.scan_done = (scan_r == Full) || hit_r;
  assign stat.lru_done  = !rm_act_r && !app_r;

  assign out_status = st_r;
  assign out_frame_index = fi_r;
  assign out_result_page_id = rp_r;
  assign out_writeback_valid = wb_r;
  assign out_writeback_page_id = wbp_r;
  assign out_writeback_frame = wbf_r;
  assign out_read_valid = rd_r;
  assign out_release_valid = rel_r;

  // capture request and scan one frame per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode; pg_r <= in_page_id;
      md_r <= in_mark_dirty; npg_r <= in_new_page_id;
      scan_r <= '0; hit_r <= 1'b0; hidx_r <= '0;
    end else if (cmd.scan && !stat.scan_done) begin
      if (valid_r[si] && page_r[si] == pg_r) begin
        hit_r <= 1'b1; hidx_r <= si;
      end else begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  // apply request, then compact the LRU order one entry per cycle
  always_ff @(posedge clk) begin
    logic [FW-1:0] f;
    logic [PIN_BITS-1:0] np;
    if (!rst_n) begin
      valid_r <= '0; dirty_r <= '0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        pins_r[i] <= '0; freeq_r[i] <= FW'(i);
      end
      free_cnt_r <= Full; lru_cnt_r <= '0;
      rm_act_r <= 1'b0; app_r <= 1'b0;
    end else if (cmd.exec) begin
      st_r <= ST_NOT_RES; fi_r <= '0; rp_r <= '0;
      wb_r <= 1'b0; wbp_r <= '0; wbf_r <= '0; rd_r <= 1'b0; rel_r <= 1'b0;
      f = hidx_r;
      if (op_r == OP_FETCH && hit_r) begin
        if (pins_r[f] == PinMax) st_r <= ST_OVERFLOW;
        else begin
          pins_r[f] <= pins_r[f] + 1'b1;
          rm_act_r <= 1'b1; rm_f_r <= f; rm_i_r <= '0; rm_found_r <= 1'b0;
          st_r <= ST_OK; fi_r <= f; rp_r <= pg_r;
        end
      end else if (op_r == OP_FETCH || op_r == OP_NEW) begin
        if (free_cnt_r != '0 || lru_cnt_r != '0) begin
          if (free_cnt_r != '0) begin
            f = freeq_r[0];
            for (int i = 0; i < POOL_FRAMES - 1; i++) freeq_r[i] <= freeq_r[i+1];
            free_cnt_r <= free_cnt_r - 1'b1;
          end else begin
            f = lru_r[0];
            rm_act_r <= 1'b1; rm_f_r <= f; rm_i_r <= '0; rm_found_r <= 1'b0;
          end
          if (valid_r[f] && dirty_r[f]) begin
            wb_r <= 1'b1; wbp_r <= page_r[f]; wbf_r <= f;
          end
          valid_r[f] <= 1'b1; dirty_r[f] <= 1'b0; pins_r[f] <= PIN_BITS'(1);
          page_r[f] <= (op_r == OP_FETCH) ? pg_r : npg_r;
          rp_r <= (op_r == OP_FETCH) ? pg_r : npg_r;
          st_r <= ST_OK; fi_r <= f; rd_r <= (op_r == OP_FETCH);
        end else st_r <= ST_NO_FRAME;
      end else if (op_r == OP_DELETE) begin
        if (!hit_r) st_r <= ST_OK;
        else if (pins_r[f] != '0) st_r <= ST_PINNED;
        else begin
          if (dirty_r[f]) begin wb_r <= 1'b1; wbp_r <= pg_r; wbf_r <= f; end
          rel_r <= 1'b1; valid_r[f] <= 1'b0; dirty_r[f] <= 1'b0;
          rm_act_r <= 1'b1; rm_f_r <= f; rm_i_r <= '0; rm_found_r <= 1'b0;
          if (free_cnt_r != Full) begin
            freeq_r[free_cnt_r[FW-1:0]] <= f;
            free_cnt_r <= free_cnt_r + 1'b1;
          end
          st_r <= ST_OK; fi_r <= f; rp_r <= pg_r;
        end
      end else if (op_r == OP_UNPIN) begin
        if (hit_r) begin
          if (md_r) dirty_r[f] <= 1'b1;
          if (pins_r[f] == '0) st_r <= ST_UNPINNED;
          else begin
            np = pins_r[f] - 1'b1;
            pins_r[f] <= np;
            if (np == '0) begin
              rm_act_r <= 1'b1; rm_f_r <= f; rm_i_r <= '0; rm_found_r <= 1'b0;
              app_r <= 1'b1;
            end
            st_r <= ST_OK; fi_r <= f; rp_r <= pg_r;
          end
        end
      end else if (op_r == OP_FLUSH) begin
        if (hit_r) begin
          if (dirty_r[f]) begin
            wb_r <= 1'b1; wbp_r <= pg_r; wbf_r <= f; dirty_r[f] <= 1'b0;
          end
          st_r <= ST_OK; fi_r <= f; rp_r <= pg_r;
        end
      end
    end else if (cmd.lru_step) begin
      if (rm_act_r) begin
        // walk the order; shift entries down once the frame is found
        if (rm_i_r >= lru_cnt_r) begin
          rm_act_r <= 1'b0;
          if (rm_found_r) lru_cnt_r <= lru_cnt_r - 1'b1;
        end else begin
          if (rm_found_r) lru_r[rm_i_r[FW-1:0] - 1'b1] <= lru_r[rm_i_r[FW-1:0]];
          else if (lru_r[rm_i_r[FW-1:0]] == rm_f_r) rm_found_r <= 1'b1;
          rm_i_r <= rm_i_r + 1'b1;
        end
      end else if (app_r) begin
        app_r <= 1'b0;
        if (lru_cnt_r != Full) begin
          lru_r[lru_cnt_r[FW-1:0]] <= rm_f_r;
          lru_cnt_r <= lru_cnt_r + 1'b1;
        end
      end
    end
  end
endmodule
